// ===== hw/rtl/esms_pkg.sv =====
// ----------------------------------------------------------------------------
// esms_pkg: shared types and constants of the exon structure match scorer
// Field widths, configuration register codes, match kind codes and the
// boundary difference helper used by the scoring pipeline.
// ----------------------------------------------------------------------------
package esms_pkg;

	// Field widths.
	localparam int CHROM_W    = 10;
	localparam int QB_W       = 9;
	localparam int COORD_W    = 31;
	localparam int TOL_W      = 16;
	localparam int DIV_W      = 32;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_TOL   = 1'd1;

	// Register values after reset.
	localparam logic [TOL_W-1:0] THRESHOLD_RESET = 16'd10;
	localparam logic [TOL_W-1:0] END_TOL_RESET   = 16'd100;

	// Match kind codes.
	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MULTI  = 2'd2;

	// One exon block pair as it arrives.
	typedef struct packed {
		logic [CHROM_W-1:0] query_chrom;
		logic [CHROM_W-1:0] ref_chrom;
		logic               query_strand;
		logic               ref_strand;
		logic [QB_W-1:0]    query_blocks;
		logic [QB_W-1:0]    ref_blocks;
		logic [COORD_W-1:0] query_left;
		logic [COORD_W-1:0] query_right;
		logic [COORD_W-1:0] ref_left;
		logic [COORD_W-1:0] ref_right;
		logic [COORD_W-1:0] ref_cds_left;
		logic [COORD_W-1:0] ref_cds_right;
	} item_t;

	// One score per transcript pair.
	typedef struct packed {
		logic [KIND_W-1:0] match_kind;
		logic [DIV_W-1:0]  divergence;
	} result_t;

	// Configuration register contents.
	typedef struct packed {
		logic [TOL_W-1:0] threshold;
		logic [TOL_W-1:0] end_tolerance;
	} cfg_t;

	// Per-block differences and flags handed from the compare stage to the
	// accumulate stage.
	typedef struct packed {
		logic               first;
		logic               last;
		logic               single;
		logic               header_ok;
		logic               bad;
		logic [COORD_W-1:0] d_left;
		logic [COORD_W-1:0] d_right;
	} stage_t;

	// Absolute difference of two coordinates.
	function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
	                                                input logic [COORD_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

// ===== hw/rtl/esms_stream_if.sv =====
// ----------------------------------------------------------------------------
// esms_stream_if: valid/ready stream channel
// Carries one payload per transfer; a transfer happens at a rising clock edge
// with valid and ready both high.
// ----------------------------------------------------------------------------
interface esms_stream_if #(parameter type payload_t = logic);

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

// ===== hw/rtl/esms_front.sv =====
// ----------------------------------------------------------------------------
// esms_front: input register and boundary compare stage
// Registers each incoming block pair, tracks the block position and header
// match of the current transcript, and computes the boundary differences and
// out-of-bound flags for the accumulate stage.
// ----------------------------------------------------------------------------
module esms_front #(
	parameter int MAX_BLOCKS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  esms_pkg::cfg_t    cfg,
	esms_stream_if.sink       item,
	output logic              s2_valid,
	output esms_pkg::stage_t  s2_data,
	input  logic              s2_take
);
	import esms_pkg::*;

	localparam int CW   = ($clog2(MAX_BLOCKS + 1) > QB_W) ? $clog2(MAX_BLOCKS + 1) : QB_W;
	localparam int IDXW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

	item_t            item_s1;
	logic             valid_s1;
	logic             s1_adv;
	logic [IDXW-1:0]  block_index_q;
	logic [CW-1:0]    blocks_expected_q;
	logic             header_ok_q;

	logic             first;
	logic [CW-1:0]    qb_raw;
	logic [CW-1:0]    qb_sat;
	logic [CW-1:0]    expected_cur;
	logic             last;
	logic             hdr_cur;
	logic             single;
	logic [COORD_W-1:0] dl;
	logic [COORD_W-1:0] dr;
	logic [COORD_W-1:0] dcl;
	logic [COORD_W-1:0] dcr;
	logic [COORD_W-1:0] tol;
	logic [COORD_W-1:0] thr;
	logic             lok;
	logic             rok;
	logic             use_l;
	logic             use_r;
	stage_t           stage_next;

	// Stage handshake: the input register empties when stage two can take it.
	assign s1_adv     = valid_s1 && (!s2_valid || s2_take);
	assign item.ready = !valid_s1 || s1_adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	// Block position and header decision of the current transcript.
	always_comb begin
		first  = (block_index_q == '0);
		qb_raw = CW'(item_s1.query_blocks);
		if (qb_raw == '0) begin
			qb_sat = CW'(1);
		end else if (qb_raw > CW'(MAX_BLOCKS)) begin
			qb_sat = CW'(MAX_BLOCKS);
		end else begin
			qb_sat = qb_raw;
		end
		expected_cur = first ? qb_sat : blocks_expected_q;
		last         = (CW'(block_index_q) + CW'(1)) >= expected_cur;
		hdr_cur      = first ? ((item_s1.query_chrom == item_s1.ref_chrom) &&
		                        (item_s1.query_strand == item_s1.ref_strand) &&
		                        (item_s1.query_blocks == item_s1.ref_blocks))
		                     : header_ok_q;
		single       = (expected_cur == CW'(1));
	end

	// Boundary differences and bound checks.
	always_comb begin
		dl    = absdiff(item_s1.query_left, item_s1.ref_left);
		dr    = absdiff(item_s1.query_right, item_s1.ref_right);
		dcl   = absdiff(item_s1.query_left, item_s1.ref_cds_left);
		dcr   = absdiff(item_s1.query_right, item_s1.ref_cds_right);
		tol   = COORD_W'(cfg.end_tolerance);
		thr   = COORD_W'(cfg.threshold);
		lok   = (dl < tol) || (dcl < tol);
		rok   = (dr < tol) || (dcr < tol);
		use_l = single || !first;
		use_r = single || !last;

		stage_next.first     = first;
		stage_next.last      = last;
		stage_next.single    = single;
		stage_next.header_ok = hdr_cur;
		if (single) begin
			stage_next.bad = !(lok && rok);
		end else begin
			stage_next.bad = (use_l && (dl > thr)) || (use_r && (dr > thr));
		end
		stage_next.d_left  = use_l ? dl : '0;
		stage_next.d_right = use_r ? dr : '0;
	end

	// Transcript control state advances with each transfer into stage two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_index_q     <= '0;
			blocks_expected_q <= '0;
			header_ok_q       <= 1'b0;
		end else if (s1_adv) begin
			if (last) begin
				block_index_q     <= '0;
				blocks_expected_q <= '0;
				header_ok_q       <= 1'b0;
			end else begin
				block_index_q     <= block_index_q + IDXW'(1);
				blocks_expected_q <= expected_cur;
				header_ok_q       <= hdr_cur;
			end
		end
	end

	// Stage two register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (!s2_valid || s2_take) begin
			s2_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			s2_data <= stage_next;
		end
	end

endmodule

// ===== hw/rtl/esms_accum.sv =====
// ----------------------------------------------------------------------------
// esms_accum: divergence accumulator and result register
// Sums the boundary differences of a transcript with saturation, tracks
// whether every boundary stayed in bounds, and holds the score until the
// sink takes it.
// ----------------------------------------------------------------------------
module esms_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s2_valid,
	input  esms_pkg::stage_t  s2_data,
	output logic              s2_take,
	esms_stream_if.source     result
);
	import esms_pkg::*;

	logic [DIV_W-1:0]   acc_q;
	logic               within_q;
	logic               out_valid_q;
	result_t            result_q;

	logic [DIV_W-1:0]   base;
	logic [DIV_W+1:0]   sum_wide;
	logic [DIV_W-1:0]   sum_sat;
	logic               within_cur;
	result_t            result_next;

	// A block without a score moves on at once; a last block waits for room.
	assign s2_take = s2_valid && (!s2_data.last || !out_valid_q || result.ready);

	// Saturating sum and the running in-bounds flag.
	always_comb begin
		base       = s2_data.first ? '0 : acc_q;
		sum_wide   = (DIV_W + 2)'(base) + (DIV_W + 2)'(s2_data.d_left) +
		             (DIV_W + 2)'(s2_data.d_right);
		sum_sat    = (sum_wide[DIV_W+1:DIV_W] != 2'b00) ? '1 : sum_wide[DIV_W-1:0];
		within_cur = (s2_data.first || within_q) && !s2_data.bad;

		if (!s2_data.header_ok) begin
			result_next.match_kind = KIND_NONE;
			result_next.divergence = '0;
		end else begin
			result_next.match_kind = !within_cur    ? KIND_NONE :
			                         s2_data.single ? KIND_SINGLE : KIND_MULTI;
			result_next.divergence = sum_sat;
		end
	end

	// Accumulator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			within_q <= 1'b1;
		end else if (s2_take) begin
			acc_q    <= sum_sat;
			within_q <= within_cur;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_take && s2_data.last) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_take && s2_data.last) begin
			result_q <= result_next;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = result_q;

endmodule

// ===== hw/rtl/exon_structure_match_scorer_top.sv =====
// ----------------------------------------------------------------------------
// exon_structure_match_scorer_top: exon structure match scorer
// Scores a query transcript against a reference transcript, one exon block
// pair per transfer, and returns one match kind and divergence per pair.
// ----------------------------------------------------------------------------
// The block takes one exon block pair per clock cycle and keeps that rate for
// as long as scores are taken; only a score held in the result register with
// ready low stops the pipeline, and then only once the next last block
// reaches it. Each pair passes an input register, a compare stage that
// works out the boundary differences, and an accumulate stage that loads the
// result register, so the score of a transcript is offered from the result
// register once its last block has passed the input and compare stages.
// The first block of a transcript sets the block count, capped at
// MAX_BLOCKS, and the header check; header fields of later blocks are
// ignored. Registers are written through cfg_we, cfg_index and cfg_wdata;
// the user must do so only while no transcript is in flight; the block does not enforce it.
module exon_structure_match_scorer_top #(
	parameter int MAX_BLOCKS = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [esms_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [esms_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	esms_stream_if.sink                       item,
	esms_stream_if.source                     result
);
	import esms_pkg::*;

	cfg_t   cfg_q;
	logic   s2_valid;
	stage_t s2_data;
	logic   s2_take;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold     <= THRESHOLD_RESET;
			cfg_q.end_tolerance <= END_TOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRESHOLD: cfg_q.threshold     <= TOL_W'(cfg_wdata);
				CFG_END_TOL:   cfg_q.end_tolerance <= TOL_W'(cfg_wdata);
				default:       cfg_q               <= cfg_q;
			endcase
		end
	end

	esms_front #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.item     (item),
		.s2_valid (s2_valid),
		.s2_data  (s2_data),
		.s2_take  (s2_take)
	);

	esms_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.s2_valid (s2_valid),
		.s2_data  (s2_data),
		.s2_take  (s2_take),
		.result   (result)
	);

	// A stalled block in the compare stage keeps its contents.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid && !s2_take |=> s2_valid && $stable(s2_data))
		else $error("compare stage changed while stalled");

	// A last block never overwrites a score that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid && s2_data.last && result.valid && !result.ready |-> !s2_take)
		else $error("score overwritten before transfer");

	// Only defined match kinds leave the block.
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.data.match_kind == KIND_NONE ||
		                  result.data.match_kind == KIND_SINGLE ||
		                  result.data.match_kind == KIND_MULTI))
		else $error("undefined match kind");

	// A header mismatch scores zero divergence.
	a_hdr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s2_take && s2_data.last && !s2_data.header_ok |=> result.data.divergence == '0)
		else $error("header mismatch with nonzero divergence");

endmodule
